FILE: rtl/core/eased_tween_generator_top_macros.svh
// ----------------------------------------------------------------------------
// Eased tween generator assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef EASED_TWEEN_GENERATOR_TOP_MACROS_SVH
`define EASED_TWEEN_GENERATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define ETG_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define ETG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ETG_ASSERT(label, clk, rstn, prop)
`define ETG_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/core/etg_pkg.sv
// ----------------------------------------------------------------------------
// Eased tween generator package
// Shared types, codes and the ease curve decoder.
// ----------------------------------------------------------------------------
package etg_pkg;

    typedef enum logic [2:0] {
        ACT_TICK        = 3'd0,
        ACT_PAUSE       = 3'd1,
        ACT_PLAY        = 3'd2,
        ACT_TOGGLE      = 3'd3,
        ACT_REWIND_LATE = 3'd4,
        ACT_REWIND      = 3'd5,
        ACT_STOP_LOOP   = 3'd6,
        ACT_ARM         = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        REG_START_VALUE  = 3'd0,
        REG_END_VALUE    = 3'd1,
        REG_DURATION     = 3'd2,
        REG_START_DELAY  = 3'd3,
        REG_LOOP_DELAY   = 3'd4,
        REG_LOOP_MODE    = 3'd5,
        REG_REVERSE_LOOP = 3'd6,
        REG_EASE_CURVE   = 3'd7
    } cfg_reg_t;

    localparam logic [1:0] LOOP_OFF        = 2'd0;
    localparam logic [1:0] LOOP_WITH_DELAY = 2'd2;

    typedef enum logic [1:0] {
        CURVE_LINEAR = 2'd0,
        CURVE_IN     = 2'd1,
        CURVE_OUT    = 2'd2,
        CURVE_INOUT  = 2'd3
    } curve_kind_t;

    typedef struct packed {
        curve_kind_t kind;
        logic [2:0]  steps;
    } curve_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_APPLY  = 3'd1,
        ST_DIVIDE = 3'd2,
        ST_PREP   = 3'd3,
        ST_POWER  = 3'd4,
        ST_SHAPE  = 3'd5,
        ST_SCALE  = 3'd6,
        ST_EMIT   = 3'd7
    } state_t;

    typedef struct packed {
        logic capture;
        logic apply;
        logic div_step;
        logic div_last;
        logic ease_load;
        logic pow_step;
        logic shape;
        logic scale;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic       div_start;
        logic [2:0] pow_steps;
        logic       out_free;
    } status_t;

    function automatic curve_t curve_decode(input logic [3:0] code);
        curve_t c;
        case (code)
            4'd1:    c = '{CURVE_IN,    3'd1};
            4'd2:    c = '{CURVE_OUT,   3'd1};
            4'd3:    c = '{CURVE_INOUT, 3'd1};
            4'd4:    c = '{CURVE_IN,    3'd2};
            4'd5:    c = '{CURVE_OUT,   3'd2};
            4'd6:    c = '{CURVE_INOUT, 3'd2};
            4'd7:    c = '{CURVE_IN,    3'd3};
            4'd8:    c = '{CURVE_OUT,   3'd3};
            4'd9:    c = '{CURVE_INOUT, 3'd3};
            4'd10:   c = '{CURVE_IN,    3'd4};
            4'd11:   c = '{CURVE_OUT,   3'd4};
            4'd12:   c = '{CURVE_INOUT, 3'd4};
            default: c = '{CURVE_LINEAR, 3'd0};
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/core/etg_controller.sv
// ----------------------------------------------------------------------------
// Eased tween generator controller
// Sequences apply, divide, power, shape, scale and emit steps.
// ----------------------------------------------------------------------------
module etg_controller #(
    parameter int FRACTION_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  etg_pkg::status_t  status,
    output etg_pkg::cmd_t     cmd
);

    localparam int CNT_BITS = $clog2(FRACTION_BITS + 1);

    etg_pkg::state_t     state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= etg_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            etg_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = etg_pkg::ST_APPLY;
                end
            end
            etg_pkg::ST_APPLY: begin
                cmd.apply = 1'b1;
                cnt_next  = '0;
                state_next = status.div_start ? etg_pkg::ST_DIVIDE : etg_pkg::ST_PREP;
            end
            etg_pkg::ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(FRACTION_BITS - 1)) begin
                    cmd.div_last = 1'b1;
                    state_next   = etg_pkg::ST_PREP;
                end
            end
            etg_pkg::ST_PREP: begin
                cmd.ease_load = 1'b1;
                cnt_next      = '0;
                state_next = (status.pow_steps == 3'd0) ? etg_pkg::ST_SHAPE : etg_pkg::ST_POWER;
            end
            etg_pkg::ST_POWER: begin
                cmd.pow_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(status.pow_steps - 3'd1)) begin
                    state_next = etg_pkg::ST_SHAPE;
                end
            end
            etg_pkg::ST_SHAPE: begin
                cmd.shape  = 1'b1;
                state_next = etg_pkg::ST_SCALE;
            end
            etg_pkg::ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = etg_pkg::ST_EMIT;
            end
            etg_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = etg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = etg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/etg_datapath.sv
// ----------------------------------------------------------------------------
// Eased tween generator datapath
// Tween state, divider, power and scale multipliers and output register.
// ----------------------------------------------------------------------------
`include "eased_tween_generator_top_macros.svh"

module etg_datapath #(
    parameter int TIME_BITS     = 16,
    parameter int FRACTION_BITS = 16,
    parameter int VALUE_BITS    = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  etg_pkg::cmd_t                cmd,
    output etg_pkg::status_t             status,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [((VALUE_BITS > TIME_BITS) ? VALUE_BITS : TIME_BITS)-1:0] cfg_wdata,
    input  logic [2:0]                   s_action,
    input  logic [TIME_BITS-1:0]         s_delta_time,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [VALUE_BITS-1:0] m_value,
    output logic [FRACTION_BITS:0]       m_progress,
    output logic                         m_ended,
    output logic                         m_first_loop
);

    localparam int T = TIME_BITS;
    localparam int F = FRACTION_BITS;
    localparam int V = VALUE_BITS;
    localparam logic [F:0] ONE  = {1'b1, {F{1'b0}}};
    localparam logic [F:0] HALF = {2'b01, {(F-1){1'b0}}};

    logic [V-1:0] start_value_reg, end_value_reg;
    logic [T-1:0] duration_reg, start_delay_reg, loop_delay_reg;
    logic [1:0]   loop_mode_reg;
    logic         reverse_loop_reg;
    logic [3:0]   ease_curve_reg;

    logic [T:0]   elapsed_reg;
    logic [F:0]   raw_progress_reg;
    logic [T-1:0] active_delay_reg;
    logic armed_reg, ended_reg, paused_reg, looping_reg, reversed_reg, first_pass_reg;

    etg_pkg::action_t action_reg;
    logic [T-1:0] delta_reg;
    logic [T-1:0] rem_reg;
    logic [F-2:0] quot_reg;
    logic [F:0]   prog_reg, x_reg, p_reg, eased_reg;
    logic         lower_reg;
    logic [V:0]   mag_reg, prod_reg;
    logic         neg_reg;

    logic         m_valid_reg;
    logic [V-1:0] m_value_reg;
    logic [F:0]   m_progress_reg;
    logic         m_ended_reg, m_first_loop_reg;

    logic [T+1:0] sum, end_time;
    logic         reached, tick_live;
    logic [T:0]   rem_shift;
    logic         rem_ge;
    logic [F:0]   adj_prog, flipped, u_val;
    logic         passed, sel_u;
    logic [2*F+1:0] pow_prod;
    logic [F+4:0] p_shift;
    logic [F:0]   p_scaled;
    logic [V:0]   diff;
    logic [F+V+1:0] scale_prod;
    logic [V+1:0] val_sum;
    etg_pkg::curve_t curve;

    assign curve     = etg_pkg::curve_decode(ease_curve_reg);
    assign sum       = {1'b0, elapsed_reg} + (paused_reg ? '0 : {2'b00, delta_reg});
    assign end_time  = {2'b00, duration_reg} + {2'b00, active_delay_reg};
    assign reached   = sum >= end_time;
    assign tick_live = armed_reg && !ended_reg;

    assign status.div_start = (action_reg == etg_pkg::ACT_TICK) && tick_live && !reached
                              && (sum > {2'b00, active_delay_reg}) && (duration_reg != '0);
    assign status.pow_steps = curve.steps;
    assign status.out_free  = !m_valid_reg || m_ready;

    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = rem_shift >= {1'b0, duration_reg};

    assign flipped = ONE - raw_progress_reg;
    assign passed  = elapsed_reg > {1'b0, active_delay_reg};
    always_comb begin
        if (!reverse_loop_reg) begin
            adj_prog = raw_progress_reg;
        end else if (reversed_reg) begin
            adj_prog = passed ? flipped : raw_progress_reg;
        end else begin
            adj_prog = (passed || first_pass_reg) ? raw_progress_reg : flipped;
        end
    end

    assign u_val = ONE - adj_prog;
    assign sel_u = (curve.kind == etg_pkg::CURVE_OUT)
                   || ((curve.kind == etg_pkg::CURVE_INOUT) && (adj_prog >= HALF));

    assign pow_prod = p_reg * x_reg;
    assign p_shift  = {4'b0000, p_reg} << (curve.steps);
    assign p_scaled = p_shift[F:0];

    assign diff       = {end_value_reg[V-1], end_value_reg} - {start_value_reg[V-1], start_value_reg};
    assign scale_prod = eased_reg * mag_reg;
    assign val_sum    = {{2{start_value_reg[V-1]}}, start_value_reg}
                        + (neg_reg ? -{1'b0, prod_reg} : {1'b0, prod_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_value_reg  <= '0;
            end_value_reg    <= '0;
            duration_reg     <= '0;
            start_delay_reg  <= '0;
            loop_delay_reg   <= '0;
            loop_mode_reg    <= '0;
            reverse_loop_reg <= 1'b0;
            ease_curve_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                etg_pkg::REG_START_VALUE:  start_value_reg  <= cfg_wdata[V-1:0];
                etg_pkg::REG_END_VALUE:    end_value_reg    <= cfg_wdata[V-1:0];
                etg_pkg::REG_DURATION:     duration_reg     <= cfg_wdata[T-1:0];
                etg_pkg::REG_START_DELAY:  start_delay_reg  <= cfg_wdata[T-1:0];
                etg_pkg::REG_LOOP_DELAY:   loop_delay_reg   <= cfg_wdata[T-1:0];
                etg_pkg::REG_LOOP_MODE:    loop_mode_reg    <= cfg_wdata[1:0];
                etg_pkg::REG_REVERSE_LOOP: reverse_loop_reg <= cfg_wdata[0];
                etg_pkg::REG_EASE_CURVE:   ease_curve_reg   <= cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg      <= '0;
            raw_progress_reg <= '0;
            active_delay_reg <= '0;
            armed_reg        <= 1'b0;
            ended_reg        <= 1'b0;
            paused_reg       <= 1'b0;
            looping_reg      <= 1'b0;
            reversed_reg     <= 1'b0;
            first_pass_reg   <= 1'b1;
        end else if (cmd.apply) begin
            case (action_reg)
                etg_pkg::ACT_TICK: begin
                    if (tick_live) begin
                        if (reached) begin
                            raw_progress_reg <= ONE;
                            if (looping_reg) begin
                                elapsed_reg    <= '0;
                                first_pass_reg <= 1'b0;
                                if (loop_mode_reg == etg_pkg::LOOP_WITH_DELAY) begin
                                    active_delay_reg <= loop_delay_reg;
                                end
                                if (reverse_loop_reg) begin
                                    reversed_reg <= !reversed_reg;
                                end
                            end else begin
                                elapsed_reg <= end_time[T:0];
                                ended_reg   <= 1'b1;
                            end
                        end else begin
                            elapsed_reg <= sum[T:0];
                        end
                    end
                end
                etg_pkg::ACT_PAUSE:  paused_reg <= 1'b1;
                etg_pkg::ACT_PLAY:   paused_reg <= 1'b0;
                etg_pkg::ACT_TOGGLE: paused_reg <= !paused_reg;
                etg_pkg::ACT_REWIND_LATE: begin
                    elapsed_reg <= {1'b0, active_delay_reg};
                    ended_reg   <= 1'b0;
                end
                etg_pkg::ACT_REWIND: begin
                    elapsed_reg <= '0;
                    ended_reg   <= 1'b0;
                end
                etg_pkg::ACT_STOP_LOOP: looping_reg <= 1'b0;
                etg_pkg::ACT_ARM: begin
                    elapsed_reg      <= '0;
                    raw_progress_reg <= '0;
                    active_delay_reg <= start_delay_reg;
                    armed_reg        <= 1'b1;
                    ended_reg        <= 1'b0;
                    paused_reg       <= 1'b0;
                    looping_reg      <= (loop_mode_reg != etg_pkg::LOOP_OFF);
                    reversed_reg     <= 1'b0;
                    first_pass_reg   <= 1'b1;
                end
                default: begin
                end
            endcase
        end else if (cmd.div_last) begin
            raw_progress_reg <= {1'b0, quot_reg, rem_ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= etg_pkg::action_t'(s_action);
            delta_reg  <= s_delta_time;
        end
        if (cmd.apply) begin
            rem_reg  <= T'(sum - {2'b00, active_delay_reg});
            quot_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg  <= rem_ge ? T'(rem_shift - {1'b0, duration_reg}) : rem_shift[T-1:0];
            quot_reg <= {quot_reg[F-3:0], rem_ge};
        end
        if (cmd.ease_load) begin
            prog_reg  <= adj_prog;
            x_reg     <= sel_u ? u_val : adj_prog;
            p_reg     <= sel_u ? u_val : adj_prog;
            lower_reg <= !sel_u;
        end else if (cmd.pow_step) begin
            p_reg <= pow_prod[F +: F+1];
        end
        if (cmd.shape) begin
            case (curve.kind)
                etg_pkg::CURVE_IN:    eased_reg <= p_reg;
                etg_pkg::CURVE_OUT:   eased_reg <= ONE - p_reg;
                etg_pkg::CURVE_INOUT: eased_reg <= lower_reg ? p_scaled : ONE - p_scaled;
                default:              eased_reg <= prog_reg;
            endcase
            neg_reg <= diff[V];
            mag_reg <= diff[V] ? -diff : diff;
        end
        if (cmd.scale) begin
            prod_reg <= scale_prod[F +: V+1];
        end
        if (cmd.emit) begin
            m_value_reg      <= val_sum[V-1:0];
            m_progress_reg   <= prog_reg;
            m_ended_reg      <= ended_reg;
            m_first_loop_reg <= first_pass_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = $signed(m_value_reg);
    assign m_progress   = m_progress_reg;
    assign m_ended      = m_ended_reg;
    assign m_first_loop = m_first_loop_reg;

    `ETG_ASSERT(a_raw_progress_bound, aclk, aresetn, raw_progress_reg <= ONE)
    `ETG_ASSERT_NEXT(a_eased_bound, aclk, aresetn, cmd.shape, eased_reg <= ONE)
    `ETG_ASSERT_NEXT(a_emit_valid, aclk, aresetn, cmd.emit, m_valid_reg && !cmd.emit)

endmodule

FILE: rtl/core/eased_tween_generator_top.sv
// ----------------------------------------------------------------------------
// Eased tween generator
// Tween engine with delay, looping and polynomial easing curves.
// ----------------------------------------------------------------------------
// Usage: configure through cfg_we/cfg_index/cfg_wdata while no transaction is
// in flight, then send actions (tick, pause, play, toggle, rewinds, stop loop,
// re-arm) on the s_ channel. Every accepted transaction yields exactly one
// result on the m_ channel: eased value, progress, ended and first pass.
// Steps: after acceptance the controller runs apply, then for a tick that
// lands inside the active window a divide (one quotient bit per cycle), then
// prep, the multiplies of the power chain (0 to 4, set by the curve), shape,
// scale and emit; one item is in work at a time.
// The result sits in an output register, so the next transaction is accepted
// while the previous result waits; if the receiver stalls, a finished result
// waits in the emit step until the output register frees.
// Reset (aresetn low, synchronous) clears the configuration registers, tween
// state and output valid; the engine stays unarmed until a re-arm action.
// ----------------------------------------------------------------------------
module eased_tween_generator_top #(
    parameter int TIME_BITS     = 16,
    parameter int FRACTION_BITS = 16,
    parameter int VALUE_BITS    = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [((VALUE_BITS > TIME_BITS) ? VALUE_BITS : TIME_BITS)-1:0] cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_action,
    input  logic [TIME_BITS-1:0]         s_delta_time,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [VALUE_BITS-1:0] m_value,
    output logic [FRACTION_BITS:0]       m_progress,
    output logic                         m_ended,
    output logic                         m_first_loop
);

    etg_pkg::cmd_t    cmd;
    etg_pkg::status_t status;

    etg_controller #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    etg_datapath #(
        .TIME_BITS     (TIME_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_action     (s_action),
        .s_delta_time (s_delta_time),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_progress   (m_progress),
        .m_ended      (m_ended),
        .m_first_loop (m_first_loop)
    );

endmodule
